FILE: hdl/des_pkg.sv
// Shared types, permutation tables, S-boxes and round functions of the DES core.
package des_pkg;

    localparam int ROUNDS = 16;

    typedef enum logic [0:0] {
        CFG_CIPHER_KEY   = 1'b0,
        CFG_DECRYPT_MODE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
    } halves_t;

    // Rotation of each key half after round i, cumulative over the schedule.
    localparam logic [4:0] ROT_TOTAL [ROUNDS] = '{
        5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    localparam logic [5:0] PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
    };

    function automatic logic [27:0] rotl28(input logic [27:0] h, input logic [4:0] s);
        logic [4:0] back;
        back = 5'd28 - s;
        return (h << s) | (h >> back);
    endfunction

    // Subkey of schedule position idx, taken from the post-PC-1 key.
    function automatic logic [47:0] subkey(input logic [55:0] key, input int idx);
        logic [55:0] cd;
        logic [47:0] k;
        logic [5:0]  pos;
        cd = {rotl28(key[55:28], ROT_TOTAL[idx]), rotl28(key[27:0], ROT_TOTAL[idx])};
        for (int i = 0; i < 48; i++)
        begin
            pos = 6'd56 - PC2_TAB[i];
            k[47 - i] = cd[pos];
        end
        return k;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sub);
        logic [47:0] x;
        logic [31:0] s_out;
        logic [31:0] p_out;
        logic [5:0]  b;
        logic [5:0]  pos;
        for (int i = 0; i < 48; i++)
        begin
            pos = 6'd32 - E_TAB[i];
            x[47 - i] = r[pos[4:0]];
        end
        x = x ^ sub;
        for (int s = 0; s < 8; s++)
        begin
            b = x[47 - 6 * s -: 6];
            s_out[31 - 4 * s -: 4] = SBOX[s][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++)
        begin
            pos = 6'd32 - P_TAB[i];
            p_out[31 - i] = s_out[pos[4:0]];
        end
        return p_out;
    endfunction

endpackage

FILE: hdl/des_in_if.sv
// Input channel carrying one 64-bit plaintext or ciphertext block per item.
interface des_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_in;

    modport source (output valid, output block_in, input ready);
    modport sink (input valid, input block_in, output ready);
endinterface

FILE: hdl/des_out_if.sv
// Output channel carrying one 64-bit result block per item.
interface des_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink (input valid, input block_out, output ready);
endinterface

FILE: hdl/des_round_cell.sv
// One Feistel round stage of the pipeline, holding its block halves and valid flag.
module des_round_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             valid_in,
    input  des_pkg::halves_t data_in,
    input  logic [47:0]      subkey,
    output logic             valid,
    output des_pkg::halves_t data
);

    logic             valid_reg;
    des_pkg::halves_t data_reg;
    des_pkg::halves_t data_next;

    always_comb
    begin
        data_next.l = data_in.r;
        data_next.r = data_in.l ^ des_pkg::feistel(data_in.r, subkey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: hdl/des_feistel_block_cipher_core.sv
// Top level of the pipelined DES Feistel core with key and mode registers.
//
// Blocks arrive on in_ch, one item per 64-bit block, and leave on out_ch in the
// same order. The key is the 56-bit post-PC-1 key, written through cfg_we,
// cfg_index and cfg_data together with the decrypt mode; both are to be written
// by the user only while no item is in flight; the core does not enforce it.
// A chain of sixteen round cells, one per round, moves every block one round
// per cycle unless stalled. An accepted item passes through all sixteen cells
// to out_ch; throughput is one block per cycle whenever the chain advances.
// Subkeys are wired from the key register, in reverse order in decrypt mode.
// When the receiver stalls with a result waiting in the last cell, the whole
// chain holds and in_ch drops ready until the result is taken.
// Reset clears the key, the mode and every valid flag, so the chain starts
// empty.
module des_feistel_block_cipher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [55:0] cfg_data,
    des_in_if.sink      in_ch,
    des_out_if.source   out_ch
);

    logic [55:0] cipher_key_reg;
    logic        decrypt_mode_reg;

    logic             advance;
    logic             stage_valid [des_pkg::ROUNDS + 1];
    des_pkg::halves_t stage_data  [des_pkg::ROUNDS + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (des_pkg::cfg_index_t'(cfg_index))
                des_pkg::CFG_CIPHER_KEY:   cipher_key_reg   <= cfg_data;
                des_pkg::CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                default:                   cipher_key_reg   <= cipher_key_reg;
            endcase
        end
    end

    assign advance        = !stage_valid[des_pkg::ROUNDS] || out_ch.ready;
    assign in_ch.ready    = advance;
    assign stage_valid[0] = in_ch.valid;
    assign stage_data[0]  = des_pkg::halves_t'(in_ch.block_in);

    for (genvar i = 0; i < des_pkg::ROUNDS; i++)
    begin : g_round
        logic [47:0] enc_key;
        logic [47:0] dec_key;

        assign enc_key = des_pkg::subkey(cipher_key_reg, i);
        assign dec_key = des_pkg::subkey(cipher_key_reg, des_pkg::ROUNDS - 1 - i);

        des_round_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .valid_in (stage_valid[i]),
            .data_in  (stage_data[i]),
            .subkey   (decrypt_mode_reg ? dec_key : enc_key),
            .valid    (stage_valid[i + 1]),
            .data     (stage_data[i + 1])
        );
    end

    assign out_ch.valid     = stage_valid[des_pkg::ROUNDS];
    assign out_ch.block_out = {stage_data[des_pkg::ROUNDS].r, stage_data[des_pkg::ROUNDS].l};

endmodule
